@@ src/sbr_pkg.sv @@
// ----------------------------------------------------------------------------
// sbr_pkg: shared definitions for the servo bus reply receiver
// Sizes, protocol constants, status and action codes, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

  // Size of the parameter buffer and the widths that follow from it.
  localparam int MAX_PARAMS = 8;
  localparam int IDX_W      = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
  localparam int HDR_BYTES  = 5;
  localparam int POS_W      = $clog2(HDR_BYTES + MAX_PARAMS + 1);
  localparam int LEN_EXTRA  = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_COUNT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Packet framing.
  localparam logic [7:0] SYNC_BYTE = 8'h55;

  localparam logic [POS_W-1:0] POS_ID  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CMD = POS_W'(4);

  // Request actions.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_ID       = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_COMMAND  = 3'd4;
  localparam logic [2:0] ST_CHECKSUM = 3'd5;
  localparam logic [2:0] ST_TIMEOUT  = 3'd6;

  // Controller to datapath.
  typedef struct packed {
    logic start;       // arm for a new packet
    logic byte_en;     // consume in_rx_byte
    logic tick_en;     // count one tick
    logic out_ld_end;  // load a single final result (failure or empty success)
    logic emit_init;   // prepare to stream the parameter buffer
    logic emit_ld;     // load the next buffered parameter as a result
  } sbr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic byte_fail;   // the current byte breaks the packet
    logic byte_done;   // the current byte is a matching checksum
    logic n_zero;      // no parameters are expected
    logic tick_fail;   // the current tick reaches the timeout
    logic emit_last;   // the next parameter to emit is the final one
  } sbr_sts_t;

endpackage

`default_nettype wire

@@ src/sbr_dp.sv @@
// ----------------------------------------------------------------------------
// sbr_dp: receiver datapath
// Configuration registers, packet position and checksum tracking, the tick
// counter, the parameter buffer and the output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [7:0]                    rx_byte,
  input  wire sbr_pkg::sbr_cmd_t             cmd,
  output sbr_pkg::sbr_sts_t                  sts,
  output logic [2:0]                         out_status,
  output logic [7:0]                         out_param_byte,
  output logic                               out_last
);
  import sbr_pkg::*;

  logic [7:0]       cfg_id_r;
  logic [7:0]       cfg_cmd_r;
  logic [3:0]       cfg_count_r;
  logic [15:0]      cfg_timeout_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [15:0]      tick_inc;

  logic [7:0]       store_r [MAX_PARAMS];
  logic             store_we;
  logic [IDX_W-1:0] store_idx;

  logic [CNT_W-1:0] eff_n;
  logic [CNT_W-1:0] emit_k_r, emit_k_nxt;
  logic [CNT_W-1:0] emit_n_r, emit_n_nxt;
  logic             in_params;
  logic             byte_fail;
  logic             byte_done;
  logic [2:0]       byte_code;

  logic [2:0]       status_r, status_nxt;
  logic [7:0]       param_r, param_nxt;
  logic             last_r, last_nxt;

  // Byte checks and next state.
  always_comb begin
    eff_n = (32'(cfg_count_r) > 32'(MAX_PARAMS)) ? CNT_W'(MAX_PARAMS) : CNT_W'(cfg_count_r);
    in_params = 32'(pos_r) < (32'(HDR_BYTES) + 32'(eff_n));
    store_idx = IDX_W'(pos_r - POS_W'(HDR_BYTES));
    byte_fail = 1'b0;
    byte_done = 1'b0;
    byte_code = ST_OK;
    store_we  = 1'b0;

    if (pos_r < POS_ID) begin
      if (rx_byte != SYNC_BYTE) begin
        byte_fail = 1'b1;
        byte_code = ST_HEADER;
      end
    end else if (pos_r == POS_ID) begin
      if (rx_byte != cfg_id_r) begin
        byte_fail = 1'b1;
        byte_code = ST_ID;
      end
    end else if (pos_r == POS_LEN) begin
      if ({1'b0, rx_byte} != (9'(eff_n) + 9'(LEN_EXTRA))) begin
        byte_fail = 1'b1;
        byte_code = ST_LENGTH;
      end
    end else if (pos_r == POS_CMD) begin
      if (rx_byte != cfg_cmd_r) begin
        byte_fail = 1'b1;
        byte_code = ST_COMMAND;
      end
    end else if (in_params) begin
      store_we = cmd.byte_en;
    end else if (~sum_r != rx_byte) begin
      byte_fail = 1'b1;
      byte_code = ST_CHECKSUM;
    end else begin
      byte_done = 1'b1;
    end

    tick_inc = (tick_r != 16'hFFFF) ? tick_r + 16'd1 : tick_r;

    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    tick_nxt = tick_r;
    if (cmd.start) begin
      pos_nxt  = '0;
      sum_nxt  = '0;
      tick_nxt = '0;
    end else if (cmd.byte_en && !byte_fail && !byte_done) begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_r >= POS_ID) begin
        sum_nxt = sum_r + rx_byte;
      end
    end else if (cmd.tick_en) begin
      tick_nxt = tick_inc;
    end
  end

  assign sts.byte_fail = byte_fail;
  assign sts.byte_done = byte_done;
  assign sts.n_zero    = (eff_n == '0);
  assign sts.tick_fail = (tick_inc >= cfg_timeout_r);
  assign sts.emit_last = (CNT_W'(emit_k_r + CNT_W'(1)) == emit_n_r);

  // Result payload.
  always_comb begin
    emit_k_nxt = emit_k_r;
    emit_n_nxt = emit_n_r;
    status_nxt = status_r;
    param_nxt  = param_r;
    last_nxt   = last_r;
    if (cmd.emit_init) begin
      emit_k_nxt = '0;
      emit_n_nxt = eff_n;
    end
    if (cmd.out_ld_end) begin
      if (cmd.tick_en) begin
        status_nxt = ST_TIMEOUT;
      end else if (byte_fail) begin
        status_nxt = byte_code;
      end else begin
        status_nxt = ST_OK;
      end
      param_nxt = '0;
      last_nxt  = 1'b1;
    end else if (cmd.emit_ld) begin
      status_nxt = ST_OK;
      param_nxt  = store_r[emit_k_r[IDX_W-1:0]];
      last_nxt   = sts.emit_last;
      emit_k_nxt = emit_k_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_id_r      <= '0;
      cfg_cmd_r     <= '0;
      cfg_count_r   <= '0;
      cfg_timeout_r <= TIMEOUT_RESET;
      pos_r         <= '0;
      sum_r         <= '0;
      tick_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_EXPECTED_ID:      cfg_id_r      <= cfg_wdata[7:0];
          REG_EXPECTED_COMMAND: cfg_cmd_r     <= cfg_wdata[7:0];
          REG_PARAM_COUNT:      cfg_count_r   <= cfg_wdata[3:0];
          REG_TIMEOUT_TICKS:    cfg_timeout_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      tick_r <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_idx] <= rx_byte;
    end
    emit_k_r <= emit_k_nxt;
    emit_n_r <= emit_n_nxt;
    status_r <= status_nxt;
    param_r  <= param_nxt;
    last_r   <= last_nxt;
  end

  assign out_status     = status_r;
  assign out_param_byte = param_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

@@ src/sbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbr_ctrl: receiver controller
// Tracks whether a receive attempt is armed, sequences the parameter burst
// after a good checksum, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_action,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sbr_pkg::sbr_sts_t sts,
  output sbr_pkg::sbr_cmd_t      cmd
);
  import sbr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RECV,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready = (state_r != S_EMIT) && !out_valid_r;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_action == ACT_START) begin
          cmd.start = 1'b1;
          state_nxt = S_RECV;
        end
      end
      S_RECV: begin
        if (accept) begin
          case (in_action)
            ACT_START: begin
              cmd.start = 1'b1;
            end
            ACT_BYTE: begin
              cmd.byte_en = 1'b1;
              if (sts.byte_fail || (sts.byte_done && sts.n_zero)) begin
                cmd.out_ld_end = 1'b1;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_IDLE;
              end else if (sts.byte_done) begin
                cmd.emit_init = 1'b1;
                state_nxt     = S_EMIT;
              end
            end
            ACT_TICK: begin
              cmd.tick_en = 1'b1;
              if (sts.tick_fail) begin
                cmd.out_ld_end = 1'b1;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit_ld   = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // A new result must never overwrite one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_ld_end || cmd.emit_ld) |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending result");

  // The output register only becomes valid when a result was loaded.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_ld_end || cmd.emit_ld))
    else $error("output valid without a loaded result");

  // Emitting the final parameter ends the burst.
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_ld && sts.emit_last) |=> (state_r == S_IDLE))
    else $error("burst did not end after the final parameter");

  // The burst is entered only from a byte that carried a good checksum.
  a_burst_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && $past(state_r) != S_EMIT) |->
      $past(cmd.byte_en && sts.byte_done && !sts.n_zero))
    else $error("burst entered without a good checksum");
`endif

endmodule

`default_nettype wire

@@ src/servo_bus_reply_receiver.sv @@
// ----------------------------------------------------------------------------
// servo_bus_reply_receiver: servo bus reply packet checker
// Checks a reply packet that arrives one byte per request after a start
// request, reports the first failure as a status code, and on success
// returns the received parameter bytes as a run of results.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   -------  --------------------  -----------------------------------------
//   in       in_valid / in_ready   in_action, in_rx_byte
//   out      out_valid / out_ready out_status, out_param_byte, out_last
//   cfg      cfg_we (no wait)      cfg_index, cfg_wdata
//
// A failure, or a good reply with no parameters, loads its single result into
// the output register at the edge that takes the request.
// A good reply with N parameters moves the controller to its emit state when
// the checksum byte is taken and loads its first result from there, then one
// more per cycle while out_ready is high; the single output register sets
// that pace, and no request is taken until the final result has been taken.
// A request is refused while a result still waits in the output register.
// Reset is synchronous and active low; it disarms the receiver, clears the
// output valid and restores the register defaults. The parameter buffer is
// not cleared; only entries written in the current attempt are read.
//
// Packet layout: two sync bytes of 0x55, the device id, a length byte equal
// to the parameter count plus three, the command code, the parameters, and a
// checksum that is the inverted 8-bit sum of id through the last parameter.
// A parameter count above the buffer size is treated as the buffer size.
// Ticks counted since the start saturate at 16 bits; reaching the timeout
// register fails the attempt.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_bus_reply_receiver (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [sbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_action,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          out_status,
  output logic [7:0]                          out_param_byte,
  output logic                                out_last
);
  import sbr_pkg::*;

  // Commands from the controller and status from the datapath.
  sbr_cmd_t cmd;
  sbr_sts_t sts;

  // The controller decides what each accepted request does and paces the
  // parameter burst against the output handshake.
  sbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, checks each byte against its
  // place in the packet, keeps the checksum and tick count, buffers the
  // parameters and drives the result payload.
  sbr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .rx_byte        (in_rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_status     (out_status),
    .out_param_byte (out_param_byte),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

@@ sim/tb_servo_bus_reply_receiver.sv @@
// ----------------------------------------------------------------------------
// tb_servo_bus_reply_receiver: self-checking bench for the reply receiver
// Drives start, byte and tick requests into the receiver. Most packets are
// well formed, and the rest are broken on purpose. A behavioral copy of the
// receiver runs in the bench and predicts every status and parameter result,
// and each result the block returns is compared field by field with the
// oldest prediction. Both sides idle and stall at random. The registers are
// swept through their extremes between phases.
// ----------------------------------------------------------------------------

module tb_servo_bus_reply_receiver;

  timeunit 1ns;
  timeprecision 1ps;

  import sbr_pkg::*;

  // The unused action code is ignored by the block in every state.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int HALF_PERIOD   = 4;
  localparam int SETTLE_CYCLES = 8;
  // The receiver holds off this long once, so that the block fills up.
  localparam int HOLD_CYCLES   = 300;
  // The longest correct quiet stretch is the hold-off above; sender gaps and
  // receiver stalls are shorter. The limit allows several times that.
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] param_byte;
    logic       last;
  } reply_t;

  // Ways in which a generated packet can be damaged.
  typedef enum int {
    FLAW_NONE,
    FLAW_HEADER,
    FLAW_ID,
    FLAW_LENGTH,
    FLAW_COMMAND,
    FLAW_CHECKSUM,
    FLAW_TRUNCATE
  } packet_flaw_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_EXPECTED_ID;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_action = ACT_START;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            out_status;
  logic [7:0]            out_param_byte;
  logic                  out_last;

  // Register values as the block should hold them.
  logic [7:0]  want_id = 8'h00;
  logic [7:0]  want_cmd = 8'h00;
  logic [3:0]  want_count = 4'd0;
  logic [15:0] want_timeout = TIMEOUT_RESET;

  // Receive state of the behavioral copy.
  bit          armed = 1'b0;
  int          byte_pos = 0;
  logic [7:0]  check_sum = 8'h00;
  logic [15:0] tick_total = 16'h0000;
  logic [7:0]  param_copy [MAX_PARAMS];

  // Results predicted but not yet returned, oldest first.
  reply_t pending_replies[$];
  reply_t head;

  // Shared flags between the stimulus, the receiver side and the checker.
  bit       offering = 1'b0;
  bit       quiet = 1'b0;
  bit       hold_req = 1'b0;
  bit       ready_held = 1'b0;
  int       requests_sent = 0;
  int       results_seen = 0;
  int       errors = 0;
  bit [7:0] status_seen = '0;

  servo_bus_reply_receiver DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_param_byte (out_param_byte),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // Idle length for either side. Most gaps are zero or short, and a few are
  // long. In quiet stretches nobody idles at all.
  function automatic int idle_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] scramble();
    return 8'($urandom_range(1, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void post_reply(input logic [2:0] status, input logic [7:0] pbyte,
                                     input logic last);
    reply_t r;
    r.status = status;
    r.param_byte = pbyte;
    r.last = last;
    pending_replies.push_back(r);
  endfunction

  // Every failure disarms the receiver and gives one final result with no data.
  function automatic void post_failure(input logic [2:0] status);
    armed = 1'b0;
    post_reply(status, 8'h00, 1'b1);
  endfunction

  // Works out what one accepted request does to the receiver and queues the
  // results that it should produce.
  function automatic void predict_reply(input logic [1:0] act, input logic [7:0] data);
    int n;
    n = (want_count > MAX_PARAMS) ? MAX_PARAMS : int'(want_count);
    case (act)
      ACT_START: begin
        // A start also restarts an attempt already under way, silently.
        armed = 1'b1;
        byte_pos = 0;
        check_sum = 8'h00;
        tick_total = 16'h0000;
      end
      ACT_BYTE: if (armed) begin
        if (byte_pos < POS_ID) begin
          if (data != SYNC_BYTE) post_failure(ST_HEADER);
          else byte_pos++;
        end else if (byte_pos < HDR_BYTES) begin
          if (byte_pos == POS_ID && data != want_id) post_failure(ST_ID);
          else if (byte_pos == POS_LEN && data != 8'(n + LEN_EXTRA)) post_failure(ST_LENGTH);
          else if (byte_pos == POS_CMD && data != want_cmd) post_failure(ST_COMMAND);
          else begin
            check_sum += data;
            byte_pos++;
          end
        end else if (byte_pos < HDR_BYTES + n) begin
          param_copy[byte_pos - HDR_BYTES] = data;
          check_sum += data;
          byte_pos++;
        end else if (data != ~check_sum) begin
          post_failure(ST_CHECKSUM);
        end else begin
          armed = 1'b0;
          if (n == 0) post_reply(ST_OK, 8'h00, 1'b1);
          else for (int k = 0; k < n; k++) post_reply(ST_OK, param_copy[k], k == n - 1);
        end
      end
      ACT_TICK: if (armed) begin
        if (tick_total != 16'hFFFF) tick_total++;
        if (tick_total >= want_timeout) post_failure(ST_TIMEOUT);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one request and returns at the edge that takes it. Valid stays up
  // on return, so a request that follows with no gap is offered back to back;
  // a gap or wait_replies_done lowers it.
  task automatic send_request(input logic [1:0] act, input logic [7:0] data);
    int gap;
    bit taken;
    gap = idle_gap();
    if (gap != 0) begin
      if (offering) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_rx_byte <= data;
    offering = 1'b1;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    requests_sent++;
    predict_reply(act, data);
  endtask

  // The sender stops and waits for every predicted result, then lets the block
  // settle. Every register write goes through here first.
  task automatic wait_replies_done();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_receiver(input logic [7:0] id, input logic [7:0] cmd,
                                  input logic [3:0] count, input logic [15:0] limit);
    wait_replies_done();
    cfg_we <= 1'b1;
    cfg_index <= REG_EXPECTED_ID;
    cfg_wdata <= CFG_DATA_W'(id);
    @(posedge clk);
    cfg_index <= REG_EXPECTED_COMMAND;
    cfg_wdata <= CFG_DATA_W'(cmd);
    @(posedge clk);
    cfg_index <= REG_PARAM_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    want_id = id;
    want_cmd = cmd;
    want_count = count;
    want_timeout = limit;
  endtask

  // Builds a reply for the current registers, damages it as asked, and sends
  // it after a start. Ticks are slipped in now and then, so short timeouts can
  // cut a packet off anywhere.
  task automatic send_packet(input packet_flaw_t flaw);
    logic [7:0] frame[$];
    logic [7:0] sum;
    int n;
    int cut;
    int pick;
    n = (want_count > MAX_PARAMS) ? MAX_PARAMS : int'(want_count);
    frame.push_back(SYNC_BYTE);
    frame.push_back(SYNC_BYTE);
    frame.push_back(want_id);
    frame.push_back(8'(n + LEN_EXTRA));
    frame.push_back(want_cmd);
    repeat (n) frame.push_back(8'($urandom));
    sum = 8'h00;
    for (int i = POS_ID; i < frame.size(); i++) sum += frame[i];
    frame.push_back(~sum);
    cut = frame.size();
    case (flaw)
      FLAW_HEADER: begin
        pick = $urandom_range(0, 1);
        frame[pick] ^= scramble();
        cut = pick + 1;
      end
      FLAW_ID: begin
        frame[POS_ID] ^= scramble();
        cut = POS_ID + 1;
      end
      FLAW_LENGTH: begin
        // With an oversized count the raw count plus three is the natural
        // wrong guess, since the block saturates the count first.
        if (want_count > MAX_PARAMS && $urandom_range(0, 1) == 1)
          frame[POS_LEN] = 8'(want_count + LEN_EXTRA);
        else
          frame[POS_LEN] ^= scramble();
        cut = POS_LEN + 1;
      end
      FLAW_COMMAND: begin
        frame[POS_CMD] ^= scramble();
        cut = POS_CMD + 1;
      end
      FLAW_CHECKSUM: frame[cut - 1] ^= scramble();
      FLAW_TRUNCATE: cut = $urandom_range(1, frame.size() - 1);
      default: ;
    endcase
    send_request(ACT_START, 8'($urandom));
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 7) == 0) send_request(ACT_TICK, 8'($urandom));
      send_request(ACT_BYTE, frame[i]);
    end
  endtask

  // One random receive attempt: mostly packets, some clean and some broken,
  // plus runs of ticks after a start and stray requests of any kind.
  task automatic send_random_attempt();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_request(2'($urandom), 8'($urandom));
    end else if (pick < 18) begin
      send_request(ACT_START, 8'($urandom));
      repeat ($urandom_range(1, 8)) send_request(ACT_TICK, 8'($urandom));
    end else if (pick < 60) begin
      send_packet(FLAW_NONE);
    end else begin
      send_packet(packet_flaw_t'($urandom_range(int'(FLAW_HEADER), int'(FLAW_TRUNCATE))));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // Requests while disarmed are dropped, whatever their kind.
    send_request(ACT_BYTE, 8'h00);
    send_request(ACT_TICK, 8'hFF);
    send_request(ACT_UNUSED, 8'hA5);
    // An empty reply checked against the register defaults.
    send_packet(FLAW_NONE);
    // A second start part way through a packet throws the first one away, and
    // the unused action code is ignored while armed too.
    send_request(ACT_START, 8'h00);
    send_request(ACT_BYTE, SYNC_BYTE);
    send_request(ACT_UNUSED, 8'h5A);
    send_packet(FLAW_NONE);
    // A sync byte at the top of the byte range fails the header.
    send_request(ACT_START, 8'hFF);
    send_request(ACT_BYTE, 8'hFF);
    // The second tick of a two-tick budget ends the attempt.
    program_receiver(8'h00, 8'h00, 4'd0, 16'd2);
    send_request(ACT_START, 8'h00);
    send_request(ACT_TICK, 8'h00);
    send_request(ACT_TICK, 8'h00);
  endtask

  // Each phase reprograms every register, which first makes the sender pause
  // until every predicted result is back.
  task automatic test_register_sweep();
    int goal;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: program_receiver(8'hFF, 8'hFF, 4'd8, 16'hFFFF);
        1: program_receiver(8'h00, 8'h00, 4'd0, 16'd1);
        // A count above the buffer size is saturated by the block.
        2: program_receiver(8'($urandom), 8'($urandom), 4'd15, 16'd40);
        // A zero timeout fails on the very first tick.
        3: program_receiver(8'($urandom), 8'($urandom), 4'($urandom_range(1, 7)), 16'd0);
        4: program_receiver(8'($urandom), 8'($urandom), 4'd8, 16'd6);
        default: program_receiver(8'($urandom), 8'($urandom),
                                  4'($urandom_range(0, 9)), 16'($urandom_range(2, 30)));
      endcase
      // One phase runs with no idling on either side.
      quiet = (phase == 4);
      goal = requests_sent + 36;
      while (requests_sent < goal) send_random_attempt();
    end
    wait_replies_done();
    quiet = 1'b0;
  endtask

  // The receiver holds off for a long stretch while full packets keep coming,
  // so the parameter burst backs up and the block refuses further requests.
  task automatic test_output_backpressure();
    program_receiver(8'($urandom), 8'($urandom), 4'd8, 16'hFFFF);
    quiet = 1'b1;
    hold_req = 1'b1;
    wait (ready_held);
    repeat (3) send_packet(FLAW_NONE);
    wait_replies_done();
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Ready is high in runs, broken by random stalls, and held low once for the
  // long stretch that test_output_backpressure asks for.
  initial begin : result_taker
    int len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        ready_held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        ready_held = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        len = idle_gap();
        if (len != 0) begin
          out_ready <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  // Inputs only change at rising edges, so at the falling edge the handshake
  // is settled: a result seen with valid and ready high here is taken at the
  // next rising edge, and is compared now with the oldest prediction.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      status_seen[out_status] = 1'b1;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d byte %h last %b",
                 $time, out_status, out_param_byte, out_last);
        errors++;
      end else begin
        head = pending_replies.pop_front();
        if (out_status !== head.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, head.status, out_status);
          errors++;
        end
        if (out_param_byte !== head.param_byte) begin
          $display("%0t: param_byte mismatch, expected %h, got %h",
                   $time, head.param_byte, out_param_byte);
          errors++;
        end
        if (out_last !== head.last) begin
          $display("%0t: last mismatch, expected %b, got %b", $time, head.last, out_last);
          errors++;
        end
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int still_cycles;
    still_cycles = 0;
    while (still_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) still_cycles = 0;
      else still_cycles++;
    end
    $display("%0t: nothing accepted for %0d cycles, %0d results still awaited",
             $time, STALL_LIMIT, pending_replies.size());
    $display("servo_bus_reply_receiver regression: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_sweep();
    test_output_backpressure();
    wait_replies_done();
    $display("Sent %0d requests (idle, restart, framing faults, timeouts, bursts), %0d results",
             requests_sent, results_seen);
    $display("checked; status codes seen, one bit per code: %b", status_seen);
    if (errors == 0) begin
      $display("servo_bus_reply_receiver regression: pass");
    end else begin
      $display("servo_bus_reply_receiver regression: fail");
    end
    $finish;
  end

endmodule
